// File: rtl/core/dksc_pkg.sv
// Shared constants and types for the debounced key settings control core.
package dksc_pkg;

	localparam int NumKeys        = 4;
	localparam int KeyLineW       = 4;
	localparam int ActionKeys     = 4;
	localparam int DebounceSamples = 4;
	localparam int ThrW           = 8;

	localparam logic [ThrW-1:0] ThresholdMaxRst = 8'd99;
	localparam logic [ThrW-1:0] ThresholdRst    = 8'd0;

	localparam int KeyMode   = 0;
	localparam int KeyEdit   = 1;
	localparam int KeyRaise  = 2;
	localparam int KeyLower  = 3;

	typedef struct packed {
		logic            mode;
		logic            edit;
		logic            buzzer;
		logic            relay;
		logic [ThrW-1:0] threshold;
	} settings_t;

	typedef struct packed {
		logic [KeyLineW-1:0] keys;
		settings_t           settings;
		logic                save_req;
		logic [ThrW-1:0]     save_val;
	} result_t;

endpackage

// File: rtl/core/dksc_lane.sv
// One key lane: sample history shift register and debounced level.
module dksc_lane import dksc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic sample,
	output logic level_d,
	output logic press
);

	logic [DebounceSamples-1:0] history_q;
	logic [DebounceSamples-1:0] history_d;
	logic                       level_q;

	assign history_d = {history_q[DebounceSamples-2:0], sample};

	always_comb begin
		if (history_d == '0) begin
			level_d = 1'b0;
		end else if (history_d == '1) begin
			level_d = 1'b1;
		end else begin
			level_d = level_q;
		end
	end

	// Press edge: released before this tick, pressed after it.
	assign press = level_q & ~level_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '1;
			level_q   <= 1'b1;
		end else if (advance) begin
			history_q <= history_d;
			level_q   <= level_d;
		end
	end

endmodule

// File: rtl/core/dksc_settings.sv
// Settings machine: merges the press edges of all lanes in key order.
module dksc_settings import dksc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [ActionKeys-1:0] press,
	input  logic [ThrW-1:0]       stored_threshold,
	input  logic [ThrW-1:0]       threshold_max,
	output settings_t             settings_d,
	output logic                  save_req,
	output logic [ThrW-1:0]       save_val
);

	settings_t cur_q;

	always_comb begin
		settings_d = cur_q;
		save_req   = 1'b0;
		save_val   = '0;
		if (press[KeyMode]) begin
			settings_d.mode = ~settings_d.mode;
		end
		if (press[KeyEdit]) begin
			if (!settings_d.mode) begin
				if (settings_d.edit) begin
					save_req        = 1'b1;
					save_val        = settings_d.threshold;
					settings_d.edit = 1'b0;
				end else begin
					settings_d.edit      = 1'b1;
					settings_d.threshold = stored_threshold;
				end
			end else begin
				settings_d.buzzer = ~settings_d.buzzer;
			end
		end
		if (press[KeyRaise]) begin
			if (!settings_d.mode) begin
				if (settings_d.threshold >= threshold_max) begin
					settings_d.threshold = threshold_max;
				end else begin
					settings_d.threshold = settings_d.threshold + 1'b1;
				end
			end else begin
				settings_d.relay = 1'b1;
			end
		end
		if (press[KeyLower]) begin
			if (!settings_d.mode) begin
				if (settings_d.threshold != '0) begin
					settings_d.threshold = settings_d.threshold - 1'b1;
				end
			end else begin
				settings_d.relay = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.mode      <= 1'b0;
			cur_q.edit      <= 1'b0;
			cur_q.buzzer    <= 1'b0;
			cur_q.relay     <= 1'b0;
			cur_q.threshold <= ThresholdRst;
		end else if (advance) begin
			cur_q <= settings_d;
		end
	end

endmodule

// File: rtl/core/debounced_key_settings_control_core.sv
// Top level: key lanes, settings merge, output register with skid stage.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_stall  | key_lines, stored_threshold
//  output  | out_valid / out_stall| debounced_keys, work_mode, edit_active,
//          |                      | buzzer_enable, relay_on, threshold,
//          |                      | save_request, save_value
//  config  | cfg_we               | cfg_wdata (threshold_max)
//
// One transaction per cycle while in_stall is low; the lane and merge logic
// feed the output register, or the skid register while a result waits there.
// The skid stage lets one more transaction in while a result waits, so
// in_stall rises only once both output registers hold results.
// Reset clears key histories to released, all settings flags and the
// threshold to zero, and threshold_max to 99; no clearing pass is needed.
module debounced_key_settings_control_core import dksc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KeyLineW-1:0] key_lines,
	input  logic [ThrW-1:0]     stored_threshold,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KeyLineW-1:0] debounced_keys,
	output logic                work_mode,
	output logic                edit_active,
	output logic                buzzer_enable,
	output logic                relay_on,
	output logic [ThrW-1:0]     threshold,
	output logic                save_request,
	output logic [ThrW-1:0]     save_value,
	input  logic                cfg_we,
	input  logic [ThrW-1:0]     cfg_wdata
);

	logic [ThrW-1:0]       threshold_max_q;
	logic                  accept;
	logic                  take;
	logic [NumKeys-1:0]    level_d;
	logic [NumKeys-1:0]    press;
	logic [ActionKeys-1:0] press_act;
	logic [KeyLineW-1:0]   keys_out;
	settings_t             settings_d;
	logic                  save_req;
	logic [ThrW-1:0]       save_val;
	result_t               result;
	result_t               out_q;
	result_t               skid_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;

	// Stall only when the skid stage already holds a result.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid & ~skid_valid_q;
	assign take     = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_max_q <= ThresholdMaxRst;
		end else if (cfg_we) begin
			threshold_max_q <= cfg_wdata;
		end
	end

	// Key lanes: lines past the input field read as released.
	for (genvar i = 0; i < NumKeys; i++) begin : g_lane
		logic sample;
		if (i < KeyLineW) begin : g_line
			assign sample = key_lines[i];
		end else begin : g_none
			assign sample = 1'b1;
		end
		dksc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (accept),
			.sample  (sample),
			.level_d (level_d[i]),
			.press   (press[i])
		);
	end

	// Only the first keys carry actions; report levels of the keys that exist.
	always_comb begin
		press_act = '0;
		keys_out  = '0;
		for (int i = 0; i < ActionKeys; i++) begin
			if (i < NumKeys) begin
				press_act[i] = press[i];
			end
		end
		for (int i = 0; i < KeyLineW; i++) begin
			if (i < NumKeys) begin
				keys_out[i] = level_d[i];
			end
		end
	end

	dksc_settings u_settings (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (accept),
		.press            (press_act),
		.stored_threshold (stored_threshold),
		.threshold_max    (threshold_max_q),
		.settings_d       (settings_d),
		.save_req         (save_req),
		.save_val         (save_val)
	);

	assign result.keys     = keys_out;
	assign result.settings = settings_d;
	assign result.save_req = save_req;
	assign result.save_val = save_val;

	// Output register plus skid: refill from skid first, else from the new result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign debounced_keys = out_q.keys;
	assign work_mode      = out_q.settings.mode;
	assign edit_active    = out_q.settings.edit;
	assign buzzer_enable  = out_q.settings.buzzer;
	assign relay_on       = out_q.settings.relay;
	assign threshold      = out_q.settings.threshold;
	assign save_request   = out_q.save_req;
	assign save_value     = out_q.save_val;

endmodule
